### sv/hypervisor_register_window_defines.svh
// Assertion macros shared by the register window design.
// Every macro samples on clk_i and is disabled while rst_ni is low.
`ifndef HYPERVISOR_REGISTER_WINDOW_DEFINES_SVH
`define HYPERVISOR_REGISTER_WINDOW_DEFINES_SVH

// The property must hold at every clock edge outside reset.
`define HRW_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// The condition must never be true at a clock edge outside reset.
`define HRW_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

### sv/hrw_pkg.sv
package hrw_pkg;

  // Window placement: 64 bytes starting at the base address.
  localparam logic [15:0] WinBase  = 16'hD640;
  localparam int          OffW     = 6;
  localparam logic [5:0]  ExitOff  = 6'h3F;
  localparam logic [5:0]  UnusedOff = 6'h02;

  // Opcodes that allow a user-mode syscall trap.
  localparam logic [7:0]  OpNop    = 8'hEA;
  localparam logic [7:0]  OpClv    = 8'hB8;

  localparam logic [15:0] TrapBase  = 16'h8000;
  localparam logic [7:0]  UserRdata = 8'hFF;

  // Saved-state bytes live at offsets 0x00 to 0x12 (0x02 stays unused).
  localparam int NumSlots = 19;
  localparam int SlotAw   = $clog2(NumSlots);

  typedef struct packed {
    logic              we;
    logic [SlotAw-1:0] idx;
    logic [7:0]        wdata;
  } hrw_wr_t;

endpackage

### sv/hrw_regfile.sv
module hrw_regfile
  import hrw_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  hrw_wr_t           wr_i,
  input  logic [SlotAw-1:0] rd_idx_i,
  output logic [7:0]        rd_data_o
);

  logic [7:0] slot_q [NumSlots];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumSlots; i++) begin
        slot_q[i] <= '0;
      end
    end else if (wr_i.we) begin
      slot_q[wr_i.idx] <= wr_i.wdata;
    end
  end

  // Indexes past the last slot read as zero.
  always_comb begin
    if (rd_idx_i < SlotAw'(NumSlots)) begin
      rd_data_o = slot_q[rd_idx_i];
    end else begin
      rd_data_o = '0;
    end
  end

endmodule

### sv/hypervisor_register_window.sv
// A word accepted into the input register moves on to the result register, which
// presents it on the result port (input register, then result register).
// Throughput: one word per cycle unless the result side stalls; the two registers form
// a two-deep pipeline, so one word is still taken in while a result waits.
// Reset (rst_ni low, asynchronous): both stages empty, all saved-state bytes zero.
`include "hypervisor_register_window_defines.svh"

module hypervisor_register_window
  import hrw_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        func_i,
  input  logic [15:0] addr_i,
  input  logic [7:0]  wdata_i,
  input  logic        hyper_mode_i,
  input  logic [7:0]  next_opcode_i,
  input  logic        opcode_known_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        hit_o,
  output logic [7:0]  rdata_o,
  output logic        trap_req_o,
  output logic [15:0] trap_addr_o,
  output logic        exit_req_o
);

  // ---------------------------------------------------------------------------
  // Input register. It holds one bus access while the decode below works on it.
  // ---------------------------------------------------------------------------
  logic        s1_valid_q, s1_valid_d;
  logic        s1_func_q;
  logic [15:0] s1_addr_q;
  logic [7:0]  s1_wdata_q;
  logic        s1_hyper_q;
  logic [7:0]  s1_opcode_q;
  logic        s1_known_q;

  logic in_fire;
  logic s1_fire;
  logic s2_ready;

  // The result register can take a new word when it is empty or being drained.
  assign s2_ready   = !out_valid_o || out_ready_i;
  assign s1_fire    = s1_valid_q && s2_ready;
  assign in_ready_o = !s1_valid_q || s2_ready;
  assign in_fire    = in_valid_i && in_ready_o;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_fire) begin
      s1_valid_d = 1'b1;
    end else if (s1_fire) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_func_q   <= func_i;
      s1_addr_q   <= addr_i;
      s1_wdata_q  <= wdata_i;
      s1_hyper_q  <= hyper_mode_i;
      s1_opcode_q <= next_opcode_i;
      s1_known_q  <= opcode_known_i;
    end
  end

  // ---------------------------------------------------------------------------
  // Decode. The window is claimed when the upper ten address bits match the
  // base; the low six bits select the byte within the window.
  // ---------------------------------------------------------------------------
  logic [OffW-1:0] off;
  logic            hit;
  logic            slot_ok;
  logic            hyp_rd, hyp_wr, usr_rd, usr_wr;
  logic            opcode_ok;
  logic [7:0]      slot_rdata;
  logic [7:0]      rdata_d;
  logic            trap_d;
  logic [15:0]     trap_addr_d;
  logic            exit_d;
  hrw_wr_t         wr;

  assign off     = s1_addr_q[OffW-1:0];
  assign hit     = (s1_addr_q[15:OffW] == WinBase[15:OffW]);
  // Offset 0x02 has no storage behind it: it reads zero and ignores writes.
  assign slot_ok = (off < OffW'(NumSlots)) && (off != UnusedOff);

  assign hyp_rd = hit &&  s1_hyper_q && !s1_func_q;
  assign hyp_wr = hit &&  s1_hyper_q &&  s1_func_q;
  assign usr_rd = hit && !s1_hyper_q && !s1_func_q;
  assign usr_wr = hit && !s1_hyper_q &&  s1_func_q;

  // A user-mode write only traps ahead of one of the two marker opcodes, or
  // when the core cannot tell us which opcode follows.
  assign opcode_ok = !s1_known_q || (s1_opcode_q == OpNop) || (s1_opcode_q == OpClv);

  // The saved program counter is just two adjacent bytes of the store, so a
  // byte write to either half leaves the other half untouched.
  assign wr.we    = s1_fire && hyp_wr && slot_ok;
  assign wr.idx   = off[SlotAw-1:0];
  assign wr.wdata = s1_wdata_q;

  hrw_regfile u_regfile (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (wr),
    .rd_idx_i  (off[SlotAw-1:0]),
    .rd_data_o (slot_rdata)
  );

  always_comb begin
    rdata_d = '0;
    if (usr_rd) begin
      rdata_d = UserRdata;
    end else if (hyp_rd && slot_ok) begin
      rdata_d = slot_rdata;
    end
  end

  assign trap_d      = usr_wr && opcode_ok;
  // Entry points are four bytes apart, one per window offset.
  assign trap_addr_d = trap_d ? (TrapBase | {8'h00, off, 2'b00}) : TrapBase;
  assign exit_d      = hyp_wr && (off == ExitOff);

  // ---------------------------------------------------------------------------
  // Result register.
  // ---------------------------------------------------------------------------
  logic        out_valid_q, out_valid_d;
  logic        hit_q;
  logic [7:0]  rdata_q;
  logic        trap_q;
  logic [15:0] trap_addr_q;
  logic        exit_q;

  always_comb begin
    out_valid_d = out_valid_q;
    if (s1_fire) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      hit_q       <= hit;
      rdata_q     <= rdata_d;
      trap_q      <= trap_d;
      trap_addr_q <= trap_addr_d;
      exit_q      <= exit_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign hit_o       = hit_q;
  assign rdata_o     = rdata_q;
  assign trap_req_o  = trap_q;
  assign trap_addr_o = trap_addr_q;
  assign exit_req_o  = exit_q;

  // ---------------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------------
  `HRW_ASSERT_NEVER(a_trap_exit_excl, out_valid_o && trap_req_o && exit_req_o,
                    "trap and exit requested by the same word")
  `HRW_ASSERT(a_miss_quiet, (out_valid_o && !hit_o) |-> (rdata_o == '0 && !trap_req_o
              && !exit_req_o && trap_addr_o == TrapBase), "unclaimed word has side results")
  `HRW_ASSERT(a_no_trap_addr, (out_valid_o && !trap_req_o) |-> (trap_addr_o == TrapBase),
              "trap address moved without a trap request")
  `HRW_ASSERT(a_store_wr_hyper, wr.we |-> (s1_hyper_q && hit && s1_func_q),
              "saved-state byte written outside a hypervisor write")
  `HRW_ASSERT(a_s1_hold, (s1_valid_q && !s2_ready) |=> (s1_valid_q && $stable(s1_addr_q)),
              "input register lost a stalled word")

endmodule

### tb/sv/hypervisor_register_window_tb.sv
`timescale 1ns / 1ps

module hypervisor_register_window_tb;
  import hrw_pkg::*;

  // Saved program counter halves and the last saved-state offset.
  localparam logic [5:0] PcLowOff    = 6'h08;
  localparam logic [5:0] PcHighOff   = 6'h09;
  localparam logic [5:0] LastSlotOff = 6'(NumSlots - 1);

  typedef enum bit {
    ACC_READ  = 1'b0,
    ACC_WRITE = 1'b1
  } access_kind_e;

  typedef struct {
    access_kind_e kind;
    bit [15:0]    addr;
    bit [7:0]     wdata;
    bit           hyper;
    bit [7:0]     opcode;
    bit           known;
  } access_t;

  typedef struct packed {
    logic        hit;
    logic [7:0]  rdata;
    logic        trap_req;
    logic [15:0] trap_addr;
    logic        exit_req;
  } reply_t;

  // Shadow of the register window plus a queue of replies still owed by the block.
  class window_scoreboard;
    logic [7:0]  slot_bytes [0:NumSlots-1];
    logic [15:0] pc_shadow;
    reply_t      owed_replies [$];
    int errors, checked, n_hits, n_traps, n_exits, n_hyper_reads;

    function new();
      foreach (slot_bytes[i]) slot_bytes[i] = '0;
      pc_shadow = '0;
    endfunction

    function int outstanding();
      return owed_replies.size();
    endfunction

    // Works out the reply to one accepted word and updates the shadow state.
    function void note_access(access_t a);
      reply_t     r;
      logic [5:0] off;
      bit         is_slot;
      r.hit       = 1'b0;
      r.rdata     = '0;
      r.trap_req  = 1'b0;
      r.trap_addr = TrapBase;
      r.exit_req  = 1'b0;
      off         = a.addr[5:0];
      is_slot     = (off <= LastSlotOff) && (off != UnusedOff) &&
                    (off != PcLowOff) && (off != PcHighOff);
      if (a.addr[15:6] == WinBase[15:6]) begin
        r.hit = 1'b1;
        n_hits++;
        if (!a.hyper) begin
          if (a.kind == ACC_READ) begin
            r.rdata = UserRdata;
          end else if (!a.known || a.opcode == OpNop || a.opcode == OpClv) begin
            r.trap_req  = 1'b1;
            r.trap_addr = TrapBase + {8'h00, off, 2'b00};
            n_traps++;
          end
        end else if (a.kind == ACC_READ) begin
          n_hyper_reads++;
          if (is_slot) r.rdata = slot_bytes[off];
          else if (off == PcLowOff) r.rdata = pc_shadow[7:0];
          else if (off == PcHighOff) r.rdata = pc_shadow[15:8];
        end else begin
          if (is_slot) slot_bytes[off] = a.wdata;
          else if (off == PcLowOff) pc_shadow[7:0] = a.wdata;
          else if (off == PcHighOff) pc_shadow[15:8] = a.wdata;
          else if (off == ExitOff) begin
            r.exit_req = 1'b1;
            n_exits++;
          end
        end
      end
      owed_replies.push_back(r);
    endfunction

    task report_mismatch(string what, logic [15:0] got, logic [15:0] want);
      $display("%0t ns: mismatch on %s, got 0x%0h, expected 0x%0h", $time, what, got, want);
      errors++;
    endtask

    task check_reply(reply_t got);
      reply_t want;
      if (owed_replies.size() == 0) begin
        report_mismatch("unexpected result word", got.trap_addr, '0);
        return;
      end
      want = owed_replies.pop_front();
      checked++;
      if (got.hit !== want.hit) report_mismatch("hit", 16'(got.hit), 16'(want.hit));
      if (got.rdata !== want.rdata)
        report_mismatch("rdata", 16'(got.rdata), 16'(want.rdata));
      if (got.trap_req !== want.trap_req)
        report_mismatch("trap_req", 16'(got.trap_req), 16'(want.trap_req));
      if (got.trap_addr !== want.trap_addr)
        report_mismatch("trap_addr", got.trap_addr, want.trap_addr);
      if (got.exit_req !== want.exit_req)
        report_mismatch("exit_req", 16'(got.exit_req), 16'(want.exit_req));
    endtask
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic        func_i = 1'b0;
  logic [15:0] addr_i = '0;
  logic [7:0]  wdata_i = '0;
  logic        hyper_mode_i = 1'b0;
  logic [7:0]  next_opcode_i = '0;
  logic        opcode_known_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic        hit_o;
  logic [7:0]  rdata_o;
  logic        trap_req_o;
  logic [15:0] trap_addr_o;
  logic        exit_req_o;

  window_scoreboard sb = new();

  bit src_idle_en  = 1'b0;
  bit sink_idle_en = 1'b0;
  bit hold_req     = 1'b0;
  int words_sent   = 0;

  hypervisor_register_window uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .func_i         (func_i),
    .addr_i         (addr_i),
    .wdata_i        (wdata_i),
    .hyper_mode_i   (hyper_mode_i),
    .next_opcode_i  (next_opcode_i),
    .opcode_known_i (opcode_known_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .hit_o          (hit_o),
    .rdata_o        (rdata_o),
    .trap_req_o     (trap_req_o),
    .trap_addr_o    (trap_addr_o),
    .exit_req_o     (exit_req_o)
  );

  always #4 clk_i = ~clk_i;

  // Hard stop in case the block never drains.
  initial begin
    #2_000_000;
    $display("hypervisor_register_window_tb NOT OK");
    $finish;
  end

  // Result side: random stalls, plus one long hold-off counted here when asked.
  initial begin : result_sink
    int hold_left;
    hold_left = 0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = 60;
      end
      if (hold_left > 0) begin
        out_ready_i = 1'b0;
        hold_left--;
      end else begin
        out_ready_i = !(sink_idle_en && $urandom_range(99) < 23);
      end
    end
  end

  // Outputs are sampled at the rising edge, before the block's own updates land.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      sb.check_reply('{hit_o, rdata_o, trap_req_o, trap_addr_o, exit_req_o});
  end

  function automatic access_t mk(access_kind_e kind, bit [15:0] addr, bit [7:0] wdata,
                                 bit hyper, bit [7:0] opcode, bit known);
    access_t a;
    a.kind   = kind;
    a.addr   = addr;
    a.wdata  = wdata;
    a.hyper  = hyper;
    a.opcode = opcode;
    a.known  = known;
    return a;
  endfunction

  // Mostly well-formed window accesses with random content; some full-range noise.
  function automatic access_t random_access();
    access_t    a;
    int         pick;
    logic [5:0] off;
    a.kind  = access_kind_e'($urandom_range(1));
    a.wdata = 8'($urandom);
    a.hyper = ($urandom_range(3) != 0);
    a.known = ($urandom_range(3) != 0);
    pick    = $urandom_range(2);
    a.opcode = (pick == 0) ? OpNop : (pick == 1) ? OpClv : 8'($urandom);
    pick = $urandom_range(99);
    if (pick < 70) off = 6'($urandom_range(LastSlotOff));
    else if (pick < 80) off = ExitOff;
    else off = 6'($urandom);
    if ($urandom_range(99) < 12) a.addr = 16'($urandom);
    else a.addr = {WinBase[15:6], off};
    return a;
  endfunction

  // Offers one word and holds it until accepted; optional random gap first.
  task automatic send_access(access_t a);
    while (src_idle_en && $urandom_range(99) < 23) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i     = 1'b1;
    func_i         = a.kind;
    addr_i         = a.addr;
    wdata_i        = a.wdata;
    hyper_mode_i   = a.hyper;
    next_opcode_i  = a.opcode;
    opcode_known_i = a.known;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_access(a);
    words_sent++;
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    while (sb.outstanding() != 0) @(posedge clk_i);
  endtask

  initial begin : stimulus
    access_t directed [$];
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    src_idle_en  = 1'b1;
    sink_idle_en = 1'b1;

    // Reset values, full-scale writes, and the program counter halves.
    directed.push_back(mk(ACC_READ,  16'hD640, 8'h00, 1'b1, 8'h00, 1'b1));
    directed.push_back(mk(ACC_WRITE, 16'hD640, 8'hFF, 1'b1, 8'h00, 1'b1));
    directed.push_back(mk(ACC_READ,  16'hD640, 8'h00, 1'b1, 8'h00, 1'b1));
    directed.push_back(mk(ACC_WRITE, 16'hD648, 8'hA5, 1'b1, 8'h00, 1'b1));
    directed.push_back(mk(ACC_WRITE, 16'hD649, 8'h5A, 1'b1, 8'h00, 1'b1));
    directed.push_back(mk(ACC_READ,  16'hD648, 8'h00, 1'b1, 8'h00, 1'b1));
    directed.push_back(mk(ACC_READ,  16'hD649, 8'h00, 1'b1, 8'h00, 1'b1));
    // The hole at offset two, the last saved byte, and the unused range.
    directed.push_back(mk(ACC_WRITE, 16'hD642, 8'h77, 1'b1, 8'h00, 1'b1));
    directed.push_back(mk(ACC_READ,  16'hD642, 8'h00, 1'b1, 8'h00, 1'b1));
    directed.push_back(mk(ACC_WRITE, 16'hD652, 8'h80, 1'b1, 8'h00, 1'b1));
    directed.push_back(mk(ACC_READ,  16'hD652, 8'h00, 1'b1, 8'h00, 1'b1));
    directed.push_back(mk(ACC_WRITE, 16'hD653, 8'h11, 1'b1, 8'h00, 1'b1));
    directed.push_back(mk(ACC_READ,  16'hD653, 8'h00, 1'b1, 8'h00, 1'b1));
    // Exit request by write, and a read of the exit offset that must not exit.
    directed.push_back(mk(ACC_WRITE, 16'hD67F, 8'h00, 1'b1, 8'h00, 1'b1));
    directed.push_back(mk(ACC_READ,  16'hD67F, 8'h00, 1'b1, 8'h00, 1'b1));
    // User mode: reads give all ones, writes trap depending on the next opcode.
    directed.push_back(mk(ACC_READ,  16'hD645, 8'h00, 1'b0, 8'h00, 1'b1));
    directed.push_back(mk(ACC_WRITE, 16'hD67F, 8'h00, 1'b0, OpNop, 1'b1));
    directed.push_back(mk(ACC_WRITE, 16'hD640, 8'h3C, 1'b0, OpClv, 1'b1));
    directed.push_back(mk(ACC_WRITE, 16'hD641, 8'h3C, 1'b0, 8'h00, 1'b1));
    directed.push_back(mk(ACC_WRITE, 16'hD641, 8'h3C, 1'b0, 8'hFF, 1'b0));
    // Addresses just outside the window and at the ends of the bus.
    directed.push_back(mk(ACC_READ,  16'hD63F, 8'h00, 1'b1, 8'h00, 1'b1));
    directed.push_back(mk(ACC_WRITE, 16'hD680, 8'hFF, 1'b0, OpNop, 1'b0));
    directed.push_back(mk(ACC_READ,  16'h0000, 8'h00, 1'b0, 8'h00, 1'b0));
    directed.push_back(mk(ACC_WRITE, 16'hFFFF, 8'hFF, 1'b1, 8'hFF, 1'b1));
    directed.push_back(mk(ACC_READ,  16'hD640, 8'h00, 1'b1, 8'h00, 1'b1));
    foreach (directed[i]) send_access(directed[i]);

    for (int n = 0; n < 400; n++) begin
      if (n == 50) hold_req = 1'b1;
      // A long stretch where neither side idles.
      if (n == 120) begin
        src_idle_en  = 1'b0;
        sink_idle_en = 1'b0;
      end
      if (n == 220) begin
        src_idle_en  = 1'b1;
        sink_idle_en = 1'b1;
      end
      // The sender waits here until the block has returned everything.
      if (n == 300) begin
        in_valid_i = 1'b0;
        wait_drained();
        @(negedge clk_i);
      end
      send_access(random_access());
    end
    in_valid_i = 1'b0;

    wait_drained();
    repeat (8) @(posedge clk_i);
    $display("Run covered %0d accesses (%0d results checked): %0d window hits,",
             words_sent, sb.checked, sb.n_hits);
    $display("  %0d hypervisor reads, %0d syscall traps, %0d exit requests, %0d mismatches.",
             sb.n_hyper_reads, sb.n_traps, sb.n_exits, sb.errors);
    if (sb.errors == 0) begin
      $display("hypervisor_register_window_tb OK");
    end else begin
      $display("hypervisor_register_window_tb NOT OK");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+sv
sv/hrw_pkg.sv
sv/hrw_regfile.sv
sv/hypervisor_register_window.sv
tb/sv/hypervisor_register_window_tb.sv
